// ----- sv/swe_pkg.sv -----
// ============================================================================
// swe_pkg
// Shared types and constants of the stack word executor: beat structs,
// word and status codes, ALU opcodes and state encodings.
// ============================================================================
package swe_pkg;

    localparam int STACK_DEPTH = 64;
    localparam int SP_W        = $clog2(STACK_DEPTH + 1);
    localparam int ADDR_W      = $clog2(STACK_DEPTH);
    localparam int CELL_W      = 64;

    typedef enum logic [3:0] {
        WC_NOP    = 4'd0,
        WC_ADD    = 4'd1,
        WC_INC    = 4'd2,
        WC_SUB    = 4'd3,
        WC_DEC    = 4'd4,
        WC_MUL    = 4'd5,
        WC_DIV    = 4'd6,
        WC_AND    = 4'd7,
        WC_OR     = 4'd8,
        WC_NOT    = 4'd9,
        WC_XOR    = 4'd10,
        WC_FORMAT = 4'd11,
        WC_PRINT  = 4'd12
    } t_word_code;

    localparam logic [3:0] WC_LAST = WC_PRINT;

    typedef enum logic [2:0] {
        ST_OK      = 3'd0,
        ST_UNDER   = 3'd1,
        ST_BADCODE = 3'd2,
        ST_FULL    = 3'd3,
        ST_DIVZERO = 3'd4
    } t_status;

    localparam logic KIND_PUSH = 1'b0;

    localparam logic [1:0] FMT_INT  = 2'd0;
    localparam logic [1:0] FMT_CHAR = 2'd1;
    localparam logic [1:0] FMT_HEX  = 2'd2;

    // character pairs recognized by format
    localparam logic [CELL_W-1:0] FMT_INT_A  = 64'h6574;
    localparam logic [CELL_W-1:0] FMT_INT_B  = 64'h6570;
    localparam logic [CELL_W-1:0] FMT_CHAR_A = 64'h5B57;
    localparam logic [CELL_W-1:0] FMT_CHAR_B = 64'h7B26;

    typedef enum logic [3:0] {
        ALU_ADD,
        ALU_SUB,
        ALU_INC,
        ALU_DEC,
        ALU_NOT,
        ALU_AND,
        ALU_OR,
        ALU_XOR,
        ALU_MUL,
        ALU_DIV,
        ALU_FMT
    } t_alu_op;

    typedef struct packed {
        logic    start;
        t_alu_op op;
    } t_alu_req;

    typedef enum logic [1:0] {
        AS_IDLE,
        AS_MUL,
        AS_DIV,
        AS_FIX
    } t_alu_state;

    typedef enum logic [2:0] {
        S_IDLE,
        S_DECODE,
        S_OPRD,
        S_ALU,
        S_TOPLD,
        S_DONE
    } t_seq_state;

    typedef struct packed {
        logic               kind;
        logic [3:0]         word_code;
        logic signed [63:0] push_value;
    } t_in;

    typedef struct packed {
        logic [2:0]         status;
        logic [6:0]         depth;
        logic signed [63:0] top_value;
        logic               print_valid;
        logic [1:0]         print_format;
        logic signed [63:0] print_value;
    } t_out;

endpackage

// ----- sv/swe_stack_mem.sv -----
// ============================================================================
// swe_stack_mem
// Data stack cell storage: one write port, one read port, registered read.
// ============================================================================
module swe_stack_mem
    import swe_pkg::*;
(
    input  logic              i_clk,
    input  logic              i_wr_en,
    input  logic [ADDR_W-1:0] i_wr_addr,
    input  logic [CELL_W-1:0] i_wr_data,
    input  logic [ADDR_W-1:0] i_rd_addr,
    output logic [CELL_W-1:0] o_rd_data
);

    logic [CELL_W-1:0] r_mem [STACK_DEPTH];
    logic [CELL_W-1:0] r_rd_data;

    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            r_mem[i_wr_addr] <= i_wr_data;
        end
    end

    always_ff @(posedge i_clk) begin
        r_rd_data <= r_mem[i_rd_addr];
    end

    assign o_rd_data = r_rd_data;

endmodule

// ----- sv/swe_alu.sv -----
// ============================================================================
// swe_alu
// Shared arithmetic unit: registered logic and add ops, shift-add
// multiply and restoring signed divide, one bit per cycle.
// ============================================================================
module swe_alu
    import swe_pkg::*;
(
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  t_alu_req          i_req,
    input  logic [CELL_W-1:0] i_a,
    input  logic [CELL_W-1:0] i_b,
    output logic              o_done,
    output logic [CELL_W-1:0] o_result
);

    localparam int CNT_W = $clog2(CELL_W);

    t_alu_state        r_state, n_state;
    logic              r_done, n_done;
    logic [CELL_W-1:0] r_result, n_result;
    logic [CELL_W-1:0] r_acc, n_acc;
    logic [CELL_W-1:0] r_x, n_x;
    logic [CELL_W-1:0] r_y, n_y;
    logic [CELL_W-1:0] r_rem, n_rem;
    logic [CNT_W-1:0]  r_cnt, n_cnt;
    logic              r_neg, n_neg;

    logic [CELL_W-1:0] mul_sum;
    logic [CELL_W:0]   rem_sh;
    logic [CELL_W:0]   rem_diff;
    logic              rem_ge;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= AS_IDLE;
            r_done  <= 1'b0;
        end else begin
            r_state <= n_state;
            r_done  <= n_done;
        end
    end

    always_ff @(posedge i_clk) begin
        r_result <= n_result;
        r_acc    <= n_acc;
        r_x      <= n_x;
        r_y      <= n_y;
        r_rem    <= n_rem;
        r_cnt    <= n_cnt;
        r_neg    <= n_neg;
    end

    assign mul_sum  = r_acc + (r_y[0] ? r_x : '0);
    assign rem_sh   = {r_rem, r_x[CELL_W-1]};
    assign rem_diff = rem_sh - {1'b0, r_y};
    assign rem_ge   = !rem_diff[CELL_W];

    always_comb begin
        n_state  = r_state;
        n_done   = 1'b0;
        n_result = r_result;
        n_acc    = r_acc;
        n_x      = r_x;
        n_y      = r_y;
        n_rem    = r_rem;
        n_cnt    = r_cnt;
        n_neg    = r_neg;
        unique case (r_state)
            AS_IDLE: begin
                if (i_req.start) begin
                    unique case (i_req.op)
                        ALU_ADD: begin
                            n_result = i_a + i_b;
                            n_done   = 1'b1;
                        end
                        ALU_SUB: begin
                            n_result = i_a - i_b;
                            n_done   = 1'b1;
                        end
                        ALU_INC: begin
                            n_result = i_a + CELL_W'(1);
                            n_done   = 1'b1;
                        end
                        ALU_DEC: begin
                            n_result = i_a - CELL_W'(1);
                            n_done   = 1'b1;
                        end
                        ALU_NOT: begin
                            n_result = ~i_a;
                            n_done   = 1'b1;
                        end
                        ALU_AND: begin
                            n_result = i_a & i_b;
                            n_done   = 1'b1;
                        end
                        ALU_OR: begin
                            n_result = i_a | i_b;
                            n_done   = 1'b1;
                        end
                        ALU_XOR: begin
                            n_result = i_a ^ i_b;
                            n_done   = 1'b1;
                        end
                        ALU_FMT: begin
                            if (i_a == FMT_INT_A && i_b == FMT_INT_B) begin
                                n_result = CELL_W'(FMT_INT);
                            end else if (i_a == FMT_CHAR_A && i_b == FMT_CHAR_B) begin
                                n_result = CELL_W'(FMT_CHAR);
                            end else begin
                                n_result = CELL_W'(FMT_HEX);
                            end
                            n_done = 1'b1;
                        end
                        ALU_MUL: begin
                            n_acc   = '0;
                            n_x     = i_a;
                            n_y     = i_b;
                            n_cnt   = '1;
                            n_state = AS_MUL;
                        end
                        ALU_DIV: begin
                            n_neg   = i_a[CELL_W-1] ^ i_b[CELL_W-1];
                            n_x     = i_a[CELL_W-1] ? -i_a : i_a;
                            n_y     = i_b[CELL_W-1] ? -i_b : i_b;
                            n_rem   = '0;
                            n_cnt   = '1;
                            n_state = AS_DIV;
                        end
                        default: begin
                            n_result = '0;
                            n_done   = 1'b1;
                        end
                    endcase
                end
            end
            AS_MUL: begin
                n_acc = mul_sum;
                n_x   = {r_x[CELL_W-2:0], 1'b0};
                n_y   = {1'b0, r_y[CELL_W-1:1]};
                n_cnt = r_cnt - CNT_W'(1);
                if (r_cnt == '0) begin
                    n_result = mul_sum;
                    n_done   = 1'b1;
                    n_state  = AS_IDLE;
                end
            end
            AS_DIV: begin
                n_rem = rem_ge ? rem_diff[CELL_W-1:0] : rem_sh[CELL_W-1:0];
                n_x   = {r_x[CELL_W-2:0], rem_ge};
                n_cnt = r_cnt - CNT_W'(1);
                if (r_cnt == '0) begin
                    n_state = AS_FIX;
                end
            end
            AS_FIX: begin
                n_result = r_neg ? -r_x : r_x;
                n_done   = 1'b1;
                n_state  = AS_IDLE;
            end
            default: begin
                n_state = AS_IDLE;
            end
        endcase
    end

    assign o_done   = r_done;
    assign o_result = r_result;

endmodule

// ----- sv/stack_word_executor_top.sv -----
// ============================================================================
// stack_word_executor_top
// Data-stack ALU of a small stack language: push a cell or run a built-in word.
// ============================================================================
// One input beat is a push of a 64-bit literal or one built-in word; each
// input beat yields exactly one output beat with status, depth, top cell and
// the print fields.
// o_in_stall is high from the cycle after an input beat is accepted until its
// result has been loaded into the output register; one item is in work at a
// time.
// path from input accept to output valid: push, nop and errors go from decode
// straight to done; inc, dec and not take the ALU step; the other words first
// read the second operand, print then reloads the new top unless the stack is
// empty, and multiply and divide run in the one-bit-per-cycle shared unit.
// the output register holds a finished beat while i_out_stall is high; the
// next item is still accepted and is held in its last step until the output
// register frees up.
// i_rst_n (synchronous, active low) empties the stack and drops any pending
// output beat; cell storage is not cleared.
// ============================================================================
module stack_word_executor_top
    import swe_pkg::*;
(
    input  logic i_clk,
    input  logic i_rst_n,
    input  logic i_in_valid,
    output logic o_in_stall,
    input  t_in  i_in_data,
    output logic o_out_valid,
    input  logic i_out_stall,
    output t_out o_out_data
);

    t_seq_state        r_state, n_state;
    t_in               r_in, n_in;
    logic [SP_W-1:0]   r_sp, n_sp;
    logic [CELL_W-1:0] r_top, n_top;
    logic [2:0]        r_status, n_status;
    logic              r_pv, n_pv;
    logic [1:0]        r_pfmt, n_pfmt;
    logic [CELL_W-1:0] r_pval, n_pval;
    logic              r_out_valid, n_out_valid;
    t_out              r_out, n_out;

    logic [SP_W-1:0]   sp_m1, sp_m2, sp_m3;
    logic              wr_en;
    logic [ADDR_W-1:0] wr_addr;
    logic [CELL_W-1:0] wr_data;
    logic [ADDR_W-1:0] rd_addr;
    logic [CELL_W-1:0] rd_data;
    t_alu_req          alu_req;
    logic [CELL_W-1:0] alu_a, alu_b;
    logic              alu_done;
    logic [CELL_W-1:0] alu_result;
    logic              is_unary;
    t_alu_op           word_op;

    assign sp_m1 = r_sp - SP_W'(1);
    assign sp_m2 = r_sp - SP_W'(2);
    assign sp_m3 = r_sp - SP_W'(3);

    assign is_unary = (r_in.word_code == WC_INC) || (r_in.word_code == WC_DEC)
                   || (r_in.word_code == WC_NOT);

    always_comb begin
        unique case (r_in.word_code)
            WC_ADD:    word_op = ALU_ADD;
            WC_SUB:    word_op = ALU_SUB;
            WC_INC:    word_op = ALU_INC;
            WC_DEC:    word_op = ALU_DEC;
            WC_NOT:    word_op = ALU_NOT;
            WC_MUL:    word_op = ALU_MUL;
            WC_DIV:    word_op = ALU_DIV;
            WC_AND:    word_op = ALU_AND;
            WC_OR:     word_op = ALU_OR;
            WC_XOR:    word_op = ALU_XOR;
            WC_FORMAT: word_op = ALU_FMT;
            default:   word_op = ALU_ADD;
        endcase
    end

    swe_stack_mem u_mem (
        .i_clk     (i_clk),
        .i_wr_en   (wr_en),
        .i_wr_addr (wr_addr),
        .i_wr_data (wr_data),
        .i_rd_addr (rd_addr),
        .o_rd_data (rd_data)
    );

    swe_alu u_alu (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_req    (alu_req),
        .i_a      (alu_a),
        .i_b      (alu_b),
        .o_done   (alu_done),
        .o_result (alu_result)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_sp        <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_sp        <= n_sp;
            r_out_valid <= n_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_in     <= n_in;
        r_top    <= n_top;
        r_status <= n_status;
        r_pv     <= n_pv;
        r_pfmt   <= n_pfmt;
        r_pval   <= n_pval;
        r_out    <= n_out;
    end

    always_comb begin
        n_state     = r_state;
        n_in        = r_in;
        n_sp        = r_sp;
        n_top       = r_top;
        n_status    = r_status;
        n_pv        = r_pv;
        n_pfmt      = r_pfmt;
        n_pval      = r_pval;
        n_out       = r_out;
        n_out_valid = r_out_valid && i_out_stall;
        wr_en       = 1'b0;
        wr_addr     = sp_m2[ADDR_W-1:0];
        wr_data     = alu_result;
        rd_addr     = (r_state == S_OPRD) ? sp_m3[ADDR_W-1:0] : sp_m2[ADDR_W-1:0];
        alu_req     = '{start: 1'b0, op: word_op};
        alu_a       = r_top;
        alu_b       = r_top;
        unique case (r_state)
            S_IDLE: begin
                if (i_in_valid) begin
                    n_in     = i_in_data;
                    n_status = ST_OK;
                    n_pv     = 1'b0;
                    n_pfmt   = FMT_INT;
                    n_pval   = '0;
                    n_state  = S_DECODE;
                end
            end
            S_DECODE: begin
                priority if (r_in.kind == KIND_PUSH) begin
                    if (r_sp == SP_W'(STACK_DEPTH)) begin
                        n_status = ST_FULL;
                    end else begin
                        wr_en   = 1'b1;
                        wr_addr = r_sp[ADDR_W-1:0];
                        wr_data = r_in.push_value;
                        n_top   = r_in.push_value;
                        n_sp    = r_sp + SP_W'(1);
                    end
                    n_state = S_DONE;
                end else if (r_in.word_code > WC_LAST) begin
                    n_status = ST_BADCODE;
                    n_state  = S_DONE;
                end else if (r_in.word_code == WC_NOP) begin
                    n_state = S_DONE;
                end else if (is_unary) begin
                    if (r_sp == '0) begin
                        n_status = ST_UNDER;
                        n_state  = S_DONE;
                    end else begin
                        alu_req.start = 1'b1;
                        n_state       = S_ALU;
                    end
                end else if (r_sp < SP_W'(2)) begin
                    n_status = ST_UNDER;
                    n_state  = S_DONE;
                end else if (r_in.word_code == WC_DIV && r_top == '0) begin
                    n_status = ST_DIVZERO;
                    n_state  = S_DONE;
                end else begin
                    n_state = S_OPRD;
                end
            end
            S_OPRD: begin
                if (r_in.word_code == WC_PRINT) begin
                    n_pv   = 1'b1;
                    n_pfmt = (rd_data <= CELL_W'(1)) ? rd_data[1:0] : FMT_HEX;
                    n_pval = r_top;
                    n_sp   = sp_m2;
                    if (sp_m2 == '0) begin
                        n_top   = '0;
                        n_state = S_DONE;
                    end else begin
                        n_state = S_TOPLD;
                    end
                end else begin
                    alu_req.start = 1'b1;
                    alu_a         = rd_data;
                    n_state       = S_ALU;
                end
            end
            S_ALU: begin
                if (alu_done) begin
                    wr_en   = 1'b1;
                    wr_addr = is_unary ? sp_m1[ADDR_W-1:0] : sp_m2[ADDR_W-1:0];
                    n_top   = alu_result;
                    n_sp    = is_unary ? r_sp : sp_m1;
                    n_state = S_DONE;
                end
            end
            S_TOPLD: begin
                n_top   = rd_data;
                n_state = S_DONE;
            end
            S_DONE: begin
                if (!r_out_valid || !i_out_stall) begin
                    n_out.status       = r_status;
                    n_out.depth        = 7'(r_sp);
                    n_out.top_value    = (r_sp != '0) ? r_top : '0;
                    n_out.print_valid  = r_pv;
                    n_out.print_format = r_pfmt;
                    n_out.print_value  = r_pval;
                    n_out_valid        = 1'b1;
                    n_state            = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    assign o_in_stall  = (r_state != S_IDLE);
    assign o_out_valid = r_out_valid;
    assign o_out_data  = r_out;

endmodule

// ----- sv/swe_checker.sv -----
// ============================================================================
// swe_checker
// Port-level checks of the stack word executor, bound to the top level.
// ============================================================================
module swe_checker
    import swe_pkg::*;
(
    input logic i_clk,
    input logic i_rst_n,
    input logic i_in_valid,
    input logic i_in_stall,
    input logic i_out_valid,
    input logic i_out_stall,
    input t_out i_out_data
);

    // one item in work at a time
    a_busy_after_accept: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_in_valid && !i_in_stall |=> i_in_stall)
        else $error("input taken while an item is in work");

    a_print_ok: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && i_out_data.print_valid |-> i_out_data.status == ST_OK)
        else $error("print beat with error status");

    a_empty_top: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && i_out_data.depth == '0 |-> i_out_data.top_value == '0)
        else $error("nonzero top on empty stack");

    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && i_out_stall |=> i_out_valid && $stable(i_out_data))
        else $error("stalled output beat changed");

endmodule

bind stack_word_executor_top swe_checker u_swe_checker (
    .i_clk       (i_clk),
    .i_rst_n     (i_rst_n),
    .i_in_valid  (i_in_valid),
    .i_in_stall  (o_in_stall),
    .i_out_valid (o_out_valid),
    .i_out_stall (i_out_stall),
    .i_out_data  (o_out_data)
);
